@@ src/aou_pkg.sv @@
`timescale 1ns / 1ps
package aou_pkg;

  localparam int ENTRIES_DEF = 4096;
  localparam int FRAC_DEF    = 16;

  // datapath widths of the serial units, the stores and the address sum
  localparam int ACC_W  = 82;
  localparam int MPL_W  = 32;
  localparam int DIVD_W = 72;
  localparam int DIVS_W = 34;
  localparam int RAD_W  = 64;
  localparam int ROOT_W = 32;
  localparam int V_W    = 48;
  localparam int FULL_W = 27;

  localparam logic [23:0] LR_RST  = 24'd66;
  localparam logic [15:0] B1_RST  = 16'd58982;
  localparam logic [15:0] B2_RST  = 16'd65470;
  localparam logic [15:0] EPS_RST = 16'd1;
  localparam logic [12:0] RW_RST  = 13'd1;

  typedef enum logic [3:0] {
    REG_LEARNING_RATE  = 4'd0,
    REG_BETA_ONE       = 4'd1,
    REG_BETA_TWO       = 4'd2,
    REG_EPSILON        = 4'd3,
    REG_BETA_ONE_POWER = 4'd4,
    REG_BETA_TWO_POWER = 4'd5,
    REG_AMSGRAD_ENABLE = 4'd6,
    REG_ROW_WIDTH      = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic start;
    logic clear;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  typedef struct packed {
    logic wr_en;
    logic wr_max_en;
  } mem_ctl_t;

endpackage

@@ src/aou_if.sv @@
`timescale 1ns / 1ps
interface aou_in_if;
  logic               valid;
  logic               ready;
  logic signed [12:0] row_index;
  logic        [11:0] column_index;
  logic signed [31:0] gradient;
  logic signed [31:0] param_value;
  modport source (output valid, row_index, column_index, gradient, param_value,
                  input ready);
  modport sink   (input valid, row_index, column_index, gradient, param_value,
                  output ready);
endinterface

interface aou_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_param;
  logic               skipped;
  modport source (output valid, new_param, skipped, input ready);
  modport sink   (input valid, new_param, skipped, output ready);
endinterface

interface aou_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/aou_mac.sv @@
`timescale 1ns / 1ps
module aou_mac import aou_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mac_ctl_t                ctl,
  input  logic signed [ACC_W-1:0] mcand,
  input  logic        [MPL_W-1:0] mplier,
  output logic signed [ACC_W-1:0] acc,
  output unit_sts_t               sts
);

  logic                    busy_r;
  logic signed [ACC_W-1:0] mcand_r;
  logic        [MPL_W-1:0] mplier_r;
  logic signed [ACC_W-1:0] acc_r;

  // one multiplier bit per cycle, stop once the remaining bits are zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (ctl.start) begin
      busy_r   <= 1'b1;
      mcand_r  <= mcand;
      mplier_r <= mplier;
      if (ctl.clear) begin
        acc_r <= '0;
      end
    end else if (busy_r) begin
      if (mplier_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        if (mplier_r[0]) begin
          acc_r <= acc_r + mcand_r;
        end
        mcand_r  <= mcand_r <<< 1;
        mplier_r <= mplier_r >> 1;
      end
    end
  end

  assign acc      = acc_r;
  assign sts.busy = busy_r;
  assign sts.done = busy_r && (mplier_r == '0);

endmodule

@@ src/aou_div.sv @@
`timescale 1ns / 1ps
module aou_div import aou_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic [DIVD_W-1:0] quotient,
  output unit_sts_t         sts
);

  localparam int CW = $clog2(DIVD_W + 1);

  logic              busy_r;
  logic [CW-1:0]     cnt_r;
  logic [DIVD_W-1:0] quo_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVS_W-1:0] div_r;
  logic [DIVS_W:0]   shifted;
  logic [DIVS_W+1:0] diff;
  logic              ge;

  assign shifted = {rem_r, quo_r[DIVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, div_r};
  assign ge      = !diff[DIVS_W+1];

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(DIVD_W);
      quo_r  <= dividend;
      rem_r  <= '0;
      div_r  <= divisor;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
        quo_r <= {quo_r[DIVD_W-2:0], ge};
        rem_r <= ge ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
      end
    end
  end

  assign quotient = quo_r;
  assign sts.busy = busy_r;
  assign sts.done = busy_r && (cnt_r == '0);

endmodule

@@ src/aou_sqrt.sv @@
`timescale 1ns / 1ps
module aou_sqrt import aou_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic [ROOT_W-1:0] root,
  output unit_sts_t         sts
);

  localparam int CW    = $clog2(ROOT_W + 1);
  localparam int REM_W = ROOT_W + 3;

  logic              busy_r;
  logic [CW-1:0]     cnt_r;
  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [REM_W-1:0]  cur;
  logic [REM_W-1:0]  trial;
  logic [REM_W:0]    diff;
  logic              ge;

  assign cur   = {rem_r[REM_W-3:0], rad_r[RAD_W-1:RAD_W-2]};
  assign trial = REM_W'({root_r, 2'b01});
  assign diff  = {1'b0, cur} - {1'b0, trial};
  assign ge    = !diff[REM_W];

  // two radicand bits in, one root bit out per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(ROOT_W);
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r  <= cnt_r - 1'b1;
        rad_r  <= rad_r << 2;
        rem_r  <= ge ? diff[REM_W-1:0] : cur;
        root_r <= {root_r[ROOT_W-2:0], ge};
      end
    end
  end

  assign root     = root_r;
  assign sts.busy = busy_r;
  assign sts.done = busy_r && (cnt_r == '0);

endmodule

@@ src/aou_mem.sv @@
`timescale 1ns / 1ps
module aou_mem import aou_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int AW      = $clog2(ENTRIES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wr_m,
  input  logic [V_W-1:0] wr_v,
  input  logic [V_W-1:0] wr_x,
  output logic [31:0]   rd_m,
  output logic [V_W-1:0] rd_v,
  output logic [V_W-1:0] rd_x,
  output logic          clearing
);

  logic [31:0]    m_mem [ENTRIES];
  logic [V_W-1:0] v_mem [ENTRIES];
  logic [V_W-1:0] x_mem [ENTRIES];
  logic           clearing_r;
  logic [AW-1:0]  clr_r;

  // sweep every entry to zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_r      <= '0;
    end else if (clearing_r) begin
      clr_r <= clr_r + 1'b1;
      if (clr_r == AW'(ENTRIES - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      m_mem[clr_r] <= '0;
      v_mem[clr_r] <= '0;
      x_mem[clr_r] <= '0;
    end else begin
      if (ctl.wr_en) begin
        m_mem[addr] <= wr_m;
        v_mem[addr] <= wr_v;
      end
      if (ctl.wr_max_en) begin
        x_mem[addr] <= wr_x;
      end
    end
    rd_m <= m_mem[addr];
    rd_v <= v_mem[addr];
    rd_x <= x_mem[addr];
  end

  assign clearing = clearing_r;

endmodule

@@ src/adam_optimizer_update.sv @@
`timescale 1ns / 1ps
// Channel | Dir | Beat payload
// in_ch   | in  | row_index, column_index, gradient, param_value
// out_ch  | out | new_param, skipped
// cfg_ch  | in  | index, data (register write, always ready)
//
// One item at a time: three serial divisions (72 quotient bits each) set
// most of the time per item, plus the bit-serial multiplies and the
// square root. A zero denominator drops the third division. A skipped
// item goes from S_ADDR straight to S_FIN. After reset the moment stores
// are swept to zero, one entry a cycle, with in_ch.ready low until the
// sweep ends.
// A stalled result holds in the output register; the next item is taken
// meanwhile and waits at its end until that register frees.
module adam_optimizer_update import aou_pkg::*; #(
  parameter int ENTRIES       = ENTRIES_DEF,
  parameter int FRACTION_BITS = FRAC_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  aou_in_if.sink    in_ch,
  aou_out_if.source out_ch,
  aou_cfg_if.sink   cfg_ch
);

  localparam int AW   = $clog2(ENTRIES);
  localparam int SQ_W = V_W + 24;

  typedef enum logic [4:0] {
    S_IDLE, S_ADDR, S_RD, S_LD, S_M1, S_M2, S_SQ, S_V1, S_V2,
    S_DM, S_DV, S_SQS, S_SQW, S_RW, S_STW, S_WB, S_FIN
  } state_t;

  // configuration
  logic [23:0] lr_r;
  logic [15:0] b1_r, b2_r, eps_r, b1p_r, b2p_r;
  logic        ams_r;
  logic [12:0] rw_r;

  // item state
  state_t             state_r, state_nxt;
  logic signed [12:0] row_r;
  logic        [11:0] col_r;
  logic signed [31:0] g_r, p_r;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [31:0]        m_r, m_nxt;
  logic [V_W-1:0]     v_old_r, x_old_r, sq_r, sq_nxt, v_r, v_nxt;
  logic [V_W-1:0]     mhat_r, mhat_nxt, vhat_r, vhat_nxt;
  logic               neg_r, neg_nxt;
  logic signed [31:0] res_r, res_nxt;
  logic               skip_r, skip_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_np_r, out_np_nxt;
  logic               out_sk_r, out_sk_nxt;

  // unit hookup
  mac_ctl_t                mac_ctl;
  logic signed [ACC_W-1:0] mac_mcand, mac_acc;
  logic        [MPL_W-1:0] mac_mplier;
  unit_sts_t               mac_sts, div_sts, sqrt_sts;
  logic                    div_start, sqrt_start;
  logic [DIVD_W-1:0]       div_dividend, div_quo;
  logic [DIVS_W-1:0]       div_divisor;
  logic [RAD_W-1:0]        sqrt_rad;
  logic [ROOT_W-1:0]       sqrt_root;
  mem_ctl_t                mem_ctl;
  logic [31:0]             rd_m;
  logic [V_W-1:0]          rd_v, rd_x;
  logic                    clearing;

  // combinational helpers
  logic [24:0]        prod;
  logic [FULL_W-1:0]  full;
  logic               addr_ok;
  logic [16:0]        b1c, b2c, b1pc, b2pc;
  logic [31:0]        gmag, mmag;
  logic [ACC_W-1:0]   acc_u, sq_full;
  logic [V_W-1:0]     vq_cap;
  logic [SQ_W-1:0]    sq_wide;
  logic [DIVS_W-1:0]  den;
  logic [48:0]        ratio_q, ratio_z;
  logic [65:0]        st_full;
  logic [33:0]        step;
  logic signed [35:0] ps, rsum;

  logic in_acc, out_acc;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  // register writes, taken in any state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r  <= LR_RST;
      b1_r  <= B1_RST;
      b2_r  <= B2_RST;
      eps_r <= EPS_RST;
      b1p_r <= B1_RST;
      b2p_r <= B2_RST;
      ams_r <= 1'b0;
      rw_r  <= RW_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_LEARNING_RATE:  lr_r  <= cfg_ch.data;
        REG_BETA_ONE:       b1_r  <= cfg_ch.data[15:0];
        REG_BETA_TWO:       b2_r  <= cfg_ch.data[15:0];
        REG_EPSILON:        eps_r <= cfg_ch.data[15:0];
        REG_BETA_ONE_POWER: b1p_r <= cfg_ch.data[15:0];
        REG_BETA_TWO_POWER: b2p_r <= cfg_ch.data[15:0];
        REG_AMSGRAD_ENABLE: ams_r <= cfg_ch.data[0];
        REG_ROW_WIDTH:      rw_r  <= cfg_ch.data[12:0];
        default: ;
      endcase
    end
  end
  assign cfg_ch.ready = 1'b1;

  // fixed-point helpers
  assign prod    = 25'(row_r[11:0]) * 25'(rw_r);
  assign full    = FULL_W'(prod) + FULL_W'(col_r);
  assign addr_ok = !row_r[12] && (13'(col_r) < rw_r) && (full < FULL_W'(ENTRIES));
  assign b1c     = 17'h10000 - 17'(b1_r);
  assign b2c     = 17'h10000 - 17'(b2_r);
  assign b1pc    = 17'h10000 - 17'(b1p_r);
  assign b2pc    = 17'h10000 - 17'(b2p_r);
  assign gmag    = g_r[31] ? 32'(-g_r) : 32'(g_r);
  assign mmag    = m_r[31] ? 32'(-$signed(m_r)) : m_r;
  assign acc_u   = ACC_W'(mac_acc);
  assign sq_full = acc_u >> FRACTION_BITS;
  assign vq_cap  = (|div_quo[DIVD_W-1:V_W]) ? {V_W{1'b1}} : div_quo[V_W-1:0];
  assign sq_wide = SQ_W'(vhat_r) << FRACTION_BITS;
  assign den     = DIVS_W'(sqrt_root) + DIVS_W'(eps_r);
  assign ratio_q = ((|div_quo[DIVD_W-1:49]) || (div_quo[48] && (|div_quo[47:0])))
                   ? 49'h1_0000_0000_0000 : div_quo[48:0];
  assign ratio_z = (mhat_r == '0) ? 49'd0 : 49'h1_0000_0000_0000;
  assign st_full = acc_u[ACC_W-1:16];
  assign step    = (st_full > 66'h2_0000_0000) ? 34'h2_0000_0000 : st_full[33:0];
  assign ps      = 36'(p_r);
  assign rsum    = neg_r ? ps + $signed({2'b00, step}) : ps - $signed({2'b00, step});

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    m_nxt         = m_r;
    sq_nxt        = sq_r;
    v_nxt         = v_r;
    mhat_nxt      = mhat_r;
    vhat_nxt      = vhat_r;
    neg_nxt       = neg_r;
    res_nxt       = res_r;
    skip_nxt      = skip_r;
    out_valid_nxt = out_valid_r && !out_acc;
    out_np_nxt    = out_np_r;
    out_sk_nxt    = out_sk_r;
    mac_ctl       = '0;
    mac_mcand     = '0;
    mac_mplier    = '0;
    div_start     = 1'b0;
    div_dividend  = '0;
    div_divisor   = '0;
    sqrt_start    = 1'b0;
    sqrt_rad      = '0;
    mem_ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        // bad address: pass the parameter through untouched
        addr_nxt = full[AW-1:0];
        if (addr_ok) begin
          skip_nxt  = 1'b0;
          state_nxt = S_RD;
        end else begin
          skip_nxt  = 1'b1;
          res_nxt   = p_r;
          state_nxt = S_FIN;
        end
      end
      S_RD: state_nxt = S_LD;
      S_LD: begin
        mac_ctl    = '{start: 1'b1, clear: 1'b1};
        mac_mcand  = ACC_W'($signed(rd_m));
        mac_mplier = MPL_W'(b1_r);
        state_nxt  = S_M1;
      end
      S_M1: begin
        if (mac_sts.done) begin
          mac_ctl    = '{start: 1'b1, clear: 1'b0};
          mac_mcand  = ACC_W'(g_r);
          mac_mplier = MPL_W'(b1c);
          state_nxt  = S_M2;
        end
      end
      S_M2: begin
        if (mac_sts.done) begin
          m_nxt      = acc_u[47:16];
          mac_ctl    = '{start: 1'b1, clear: 1'b1};
          mac_mcand  = ACC_W'(gmag);
          mac_mplier = gmag;
          state_nxt  = S_SQ;
        end
      end
      S_SQ: begin
        if (mac_sts.done) begin
          sq_nxt     = (|sq_full[ACC_W-1:V_W]) ? {V_W{1'b1}} : sq_full[V_W-1:0];
          mac_ctl    = '{start: 1'b1, clear: 1'b1};
          mac_mcand  = ACC_W'(v_old_r);
          mac_mplier = MPL_W'(b2_r);
          state_nxt  = S_V1;
        end
      end
      S_V1: begin
        if (mac_sts.done) begin
          mac_ctl    = '{start: 1'b1, clear: 1'b0};
          mac_mcand  = ACC_W'(sq_r);
          mac_mplier = MPL_W'(b2c);
          state_nxt  = S_V2;
        end
      end
      S_V2: begin
        if (mac_sts.done) begin
          v_nxt        = acc_u[63:16];
          neg_nxt      = m_r[31];
          div_start    = 1'b1;
          div_dividend = DIVD_W'({mmag, 16'h0000});
          div_divisor  = DIVS_W'(b1pc);
          state_nxt    = S_DM;
        end
      end
      S_DM: begin
        if (div_sts.done) begin
          mhat_nxt     = div_quo[V_W-1:0];
          div_start    = 1'b1;
          div_dividend = DIVD_W'({v_r, 16'h0000});
          div_divisor  = DIVS_W'(b2pc);
          state_nxt    = S_DV;
        end
      end
      S_DV: begin
        if (div_sts.done) begin
          vhat_nxt  = (ams_r && (x_old_r > vq_cap)) ? x_old_r : vq_cap;
          state_nxt = S_SQS;
        end
      end
      S_SQS: begin
        sqrt_start = 1'b1;
        sqrt_rad   = (|sq_wide[SQ_W-1:RAD_W]) ? {RAD_W{1'b1}} : sq_wide[RAD_W-1:0];
        state_nxt  = S_SQW;
      end
      S_SQW: begin
        if (sqrt_sts.done) begin
          if (den == '0) begin
            // zero denominator: ratio is zero or saturated
            mac_ctl    = '{start: 1'b1, clear: 1'b1};
            mac_mcand  = ACC_W'(ratio_z);
            mac_mplier = MPL_W'(lr_r);
            state_nxt  = S_STW;
          end else begin
            div_start    = 1'b1;
            div_dividend = DIVD_W'(mhat_r) << FRACTION_BITS;
            div_divisor  = den;
            state_nxt    = S_RW;
          end
        end
      end
      S_RW: begin
        if (div_sts.done) begin
          mac_ctl    = '{start: 1'b1, clear: 1'b1};
          mac_mcand  = ACC_W'(ratio_q);
          mac_mplier = MPL_W'(lr_r);
          state_nxt  = S_STW;
        end
      end
      S_STW: begin
        if (mac_sts.done) begin
          if (rsum > 36'sh0_7FFF_FFFF) begin
            res_nxt = 32'sh7FFF_FFFF;
          end else if (rsum < -36'sh0_8000_0000) begin
            res_nxt = 32'sh8000_0000;
          end else begin
            res_nxt = rsum[31:0];
          end
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        mem_ctl   = '{wr_en: 1'b1, wr_max_en: ams_r};
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the output register frees
        if (!out_valid_r || out_acc) begin
          out_valid_nxt = 1'b1;
          out_np_nxt    = res_r;
          out_sk_nxt    = skip_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_acc) begin
      row_r <= in_ch.row_index;
      col_r <= in_ch.column_index;
      g_r   <= in_ch.gradient;
      p_r   <= in_ch.param_value;
    end
    if (state_r == S_LD) begin
      v_old_r <= rd_v;
      x_old_r <= rd_x;
    end
    addr_r   <= addr_nxt;
    m_r      <= m_nxt;
    sq_r     <= sq_nxt;
    v_r      <= v_nxt;
    mhat_r   <= mhat_nxt;
    vhat_r   <= vhat_nxt;
    neg_r    <= neg_nxt;
    res_r    <= res_nxt;
    skip_r   <= skip_nxt;
    out_np_r <= out_np_nxt;
    out_sk_r <= out_sk_nxt;
  end

  assign in_ch.ready      = (state_r == S_IDLE) && !clearing;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.new_param = out_np_r;
  assign out_ch.skipped   = out_sk_r;

  aou_mac u_mac (
    .clk(clk), .rst_n(rst_n), .ctl(mac_ctl), .mcand(mac_mcand),
    .mplier(mac_mplier), .acc(mac_acc), .sts(mac_sts)
  );

  aou_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .quotient(div_quo), .sts(div_sts)
  );

  aou_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_start), .radicand(sqrt_rad),
    .root(sqrt_root), .sts(sqrt_sts)
  );

  aou_mem #(.ENTRIES(ENTRIES), .AW(AW)) u_mem (
    .clk(clk), .rst_n(rst_n), .ctl(mem_ctl), .addr(addr_r),
    .wr_m(m_r), .wr_v(v_r), .wr_x(vhat_r),
    .rd_m(rd_m), .rd_v(rd_v), .rd_x(rd_x), .clearing(clearing)
  );

endmodule

@@ src/aou_checker.sv @@
`timescale 1ns / 1ps
module aou_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_new_param,
  input logic        out_skipped
);

  // result beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_new_param) && $stable(out_skipped))
    else $error("result payload changed while stalled");

  // store sweep keeps input closed right after reset
  a_clear_closed: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready)
    else $error("input open during store sweep");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !$rose(out_valid))
    else $error("input reopened or result raised right after a beat");

endmodule

bind adam_optimizer_update aou_checker u_aou_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_new_param(out_ch.new_param), .out_skipped(out_ch.skipped)
);
